// ----- hw/rtl/gldf_pkg.sv -----
// Shared types and constants of the greeting and length-prefixed deframer.
package gldf_pkg;

	// Stream phases, one-hot
	typedef enum logic [3:0] {
		PH_GREETING = 4'b0001,
		PH_HEADER   = 4'b0010,
		PH_PAYLOAD  = 4'b0100,
		PH_CLOSED   = 4'b1000
	} phase_t;

	// Reply codes
	localparam logic [1:0] REPLY_NONE   = 2'd0;
	localparam logic [1:0] REPLY_ACCEPT = 2'd1;
	localparam logic [1:0] REPLY_REJECT = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_TOO_LARGE = 2'd1;
	localparam logic [1:0] ERR_IMG_SHORT = 2'd2;

	// Framing constants
	localparam logic [31:0] GREETING_HEAD  = 32'hAAAABBBB;
	localparam logic [31:0] GREETING_SIZE  = 32'd4;
	localparam logic [31:0] IMAGE_HEAD     = 32'hABCDEEFF;
	localparam logic [3:0]  GREETING_LEN   = 4'd12;
	localparam logic [3:0]  HEADER_LEN     = 4'd8;
	localparam logic [31:0] IMAGE_MIN_EXCL = 32'd8;

	localparam int          LEN_W       = 24;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 24'h100000;

	// One result item
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       payload_is_image;
		logic       payload_last;
		logic [1:0] reply_code;
		logic [1:0] error_code;
		logic       closed;
	} result_t;

endpackage

// ----- hw/rtl/gldf_parser.sv -----
// Per-byte framing state and result logic of the deframer.
module gldf_parser (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               rx_byte,
	input  logic [gldf_pkg::LEN_W-1:0] max_payload_len,
	output gldf_pkg::result_t        res
);
	import gldf_pkg::*;

	phase_t            phase_q, phase_d;
	logic [3:0]        count_q, count_d;
	logic [63:0]       shift_q, shift_d;
	logic [LEN_W-1:0]  remaining_q, remaining_d;
	logic              is_image_q, is_image_d;

	logic [3:0]        count_inc;
	logic [63:0]       shift_in;
	logic [31:0]       head;
	logic [31:0]       size;
	logic              size_too_large;
	logic              head_is_image;

	// Candidate header value with the new byte shifted in
	assign count_inc      = count_q + 4'd1;
	assign shift_in       = {shift_q[55:0], rx_byte};
	assign head           = shift_in[63:32];
	assign size           = shift_in[31:0];
	assign size_too_large = (size[31:LEN_W] != '0) || (size[LEN_W-1:0] > max_payload_len);
	assign head_is_image  = (head == IMAGE_HEAD);

	// Next state and result for the current item
	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		shift_d     = shift_q;
		remaining_d = remaining_q;
		is_image_d  = is_image_q;
		res         = '0;
		unique case (phase_q)
			PH_GREETING: begin
				if (count_q < HEADER_LEN) begin
					shift_d = shift_in;
				end
				count_d = count_inc;
				if (count_inc == GREETING_LEN) begin
					count_d = '0;
					if ((shift_q[63:32] == GREETING_HEAD) &&
					    (shift_q[31:0] == GREETING_SIZE)) begin
						res.reply_code = REPLY_ACCEPT;
						phase_d        = PH_HEADER;
					end else begin
						res.reply_code = REPLY_REJECT;
						phase_d        = PH_CLOSED;
					end
				end
			end
			PH_HEADER: begin
				shift_d = shift_in;
				count_d = count_inc;
				if (count_inc == HEADER_LEN) begin
					count_d = '0;
					if (size_too_large) begin
						res.error_code = ERR_TOO_LARGE;
						phase_d        = PH_CLOSED;
					end else if (head_is_image && (size <= IMAGE_MIN_EXCL)) begin
						res.error_code = ERR_IMG_SHORT;
						phase_d        = PH_CLOSED;
					end else begin
						is_image_d  = head_is_image;
						remaining_d = size[LEN_W-1:0];
						if (size != '0) begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				res.payload_byte     = rx_byte;
				res.payload_valid    = 1'b1;
				res.payload_is_image = is_image_q;
				if (remaining_q <= LEN_W'(1)) begin
					res.payload_last = 1'b1;
					remaining_d      = '0;
					phase_d          = PH_HEADER;
				end else begin
					remaining_d = remaining_q - LEN_W'(1);
				end
			end
			PH_CLOSED: begin
				phase_d = PH_CLOSED;
			end
			default: begin
				phase_d = PH_CLOSED;
			end
		endcase
		res.closed = (phase_d == PH_CLOSED);
	end

	// Advance the framing state on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_GREETING;
			count_q     <= '0;
			shift_q     <= '0;
			remaining_q <= '0;
			is_image_q  <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			count_q     <= count_d;
			shift_q     <= shift_d;
			remaining_q <= remaining_d;
			is_image_q  <= is_image_d;
		end
	end

endmodule

// ----- hw/rtl/greeting_and_length_prefixed_deframer.sv -----
// Each item is held in the input register, then its result in the result register.
// Throughput: one item per cycle; the input register, the framing logic and
// the result register form a two-stage pipe that stalls only when the output is held.
// Reset: arst_n clears the pipe and the framing state to the greeting phase and
// sets max_payload_len to 1048576; the block accepts items in the first cycle after.
module greeting_and_length_prefixed_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,     // max_payload_len
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,       // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,       // [7:0] payload_byte, [9:8] reply_code,
	                                   // [11:10] error_code, [12] closed, rest zero
	output logic [1:0]  m_tuser,       // [0] payload_valid, [1] payload_is_image
	output logic        m_tlast        // payload_last
);
	import gldf_pkg::*;

	logic [LEN_W-1:0] max_len_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             valid_s2;
	result_t          res_s2;
	result_t          res;
	logic             advance;

	// Move the input stage forward when the result register is empty or being read
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Hold the payload length limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	gldf_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.rx_byte         (byte_s1),
		.max_payload_len (max_len_q),
		.res             (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	// Pack the result item
	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, res_s2.closed, res_s2.error_code, res_s2.reply_code,
	                   res_s2.payload_byte};
	assign m_tuser  = {res_s2.payload_is_image, res_s2.payload_valid};
	assign m_tlast  = res_s2.payload_last;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the greeting and length-prefixed deframer.
module tb_top;

	import gldf_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RANDOM_ITEMS = 1150;
	localparam int unsigned LONG_HOLD    = 250;

	// Typed results for the opening rows
	localparam result_t QUIET   = '0;
	localparam result_t GREETED = '{8'h00, 1'b0, 1'b0, 1'b0, REPLY_ACCEPT, ERR_NONE, 1'b0};
	localparam result_t LAST_FF = '{8'hFF, 1'b1, 1'b0, 1'b1, REPLY_NONE, ERR_NONE, 1'b0};

	typedef struct {
		logic [7:0] rx;
		bit         typed;
		result_t    want;
	} stim_row_t;

	// Accepted greeting, an empty packet, then a one-byte unknown packet
	stim_row_t opening_rows [29] = '{
		'{8'hAA, 1'b1, QUIET}, '{8'hAA, 1'b1, QUIET}, '{8'hBB, 1'b1, QUIET},
		'{8'hBB, 1'b1, QUIET}, '{8'h00, 1'b1, QUIET}, '{8'h00, 1'b1, QUIET},
		'{8'h00, 1'b1, QUIET}, '{8'h04, 1'b1, QUIET}, '{8'hFF, 1'b1, QUIET},
		'{8'h00, 1'b1, QUIET}, '{8'h5A, 1'b1, QUIET}, '{8'hA5, 1'b1, GREETED},
		'{8'h00, 1'b1, QUIET}, '{8'h00, 1'b1, QUIET}, '{8'h00, 1'b1, QUIET},
		'{8'h00, 1'b1, QUIET}, '{8'h00, 1'b1, QUIET}, '{8'h00, 1'b1, QUIET},
		'{8'h00, 1'b1, QUIET}, '{8'h00, 1'b1, QUIET},
		'{8'hFF, 1'b0, QUIET}, '{8'hFF, 1'b0, QUIET}, '{8'hFF, 1'b0, QUIET},
		'{8'hFF, 1'b0, QUIET}, '{8'h00, 1'b0, QUIET}, '{8'h00, 1'b0, QUIET},
		'{8'h00, 1'b0, QUIET}, '{8'h01, 1'b0, QUIET},
		'{8'hFF, 1'b1, LAST_FF}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [23:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// Predictor state
	phase_t            frame_phase = PH_GREETING;
	logic [3:0]        hdr_count = '0;
	logic [63:0]       hdr_shift = '0;
	logic [31:0]       pay_left = '0;
	logic              cur_image = 1'b0;
	logic [LEN_W-1:0]  max_len = MAX_LEN_RESET;

	result_t     pending_results[$];
	int unsigned bytes_sent = 0;
	int unsigned results_seen = 0;
	int unsigned err_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_calm = 0;
	int unsigned recv_calm = 0;

	greeting_and_length_prefixed_deframer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Advance the framing state by one received byte and return its result item
	function automatic result_t deframe_byte(input logic [7:0] b);
		result_t     r;
		logic [31:0] head_word;
		logic [31:0] size_word;
		r = '0;
		head_word = hdr_shift[63:32];
		size_word = hdr_shift[31:0];
		case (frame_phase)
			PH_GREETING: begin
				// the connection id bytes are counted but not kept
				if (hdr_count < HEADER_LEN)
					hdr_shift = {hdr_shift[55:0], b};
				hdr_count = hdr_count + 4'd1;
				if (hdr_count >= GREETING_LEN) begin
					head_word = hdr_shift[63:32];
					size_word = hdr_shift[31:0];
					hdr_count = '0;
					hdr_shift = '0;
					if (head_word == GREETING_HEAD && size_word == GREETING_SIZE) begin
						r.reply_code = REPLY_ACCEPT;
						frame_phase = PH_HEADER;
					end else begin
						r.reply_code = REPLY_REJECT;
						frame_phase = PH_CLOSED;
					end
				end
			end
			PH_HEADER: begin
				hdr_shift = {hdr_shift[55:0], b};
				hdr_count = hdr_count + 4'd1;
				if (hdr_count >= HEADER_LEN) begin
					head_word = hdr_shift[63:32];
					size_word = hdr_shift[31:0];
					hdr_count = '0;
					hdr_shift = '0;
					// size limit wins over the short image check
					if (size_word > {8'd0, max_len}) begin
						r.error_code = ERR_TOO_LARGE;
						frame_phase = PH_CLOSED;
					end else if (head_word == IMAGE_HEAD && size_word <= IMAGE_MIN_EXCL) begin
						r.error_code = ERR_IMG_SHORT;
						frame_phase = PH_CLOSED;
					end else begin
						cur_image = (head_word == IMAGE_HEAD);
						pay_left = size_word;
						if (size_word != 0)
							frame_phase = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				r.payload_byte = b;
				r.payload_valid = 1'b1;
				r.payload_is_image = cur_image;
				if (pay_left <= 1) begin
					r.payload_last = 1'b1;
					pay_left = '0;
					frame_phase = PH_HEADER;
				end else begin
					pay_left = pay_left - 1;
				end
			end
			default: begin
				frame_phase = PH_CLOSED;
			end
		endcase
		r.closed = (frame_phase == PH_CLOSED);
		return r;
	endfunction

	// Draw an idle count, with occasional runs of back-to-back items
	function automatic int unsigned draw_gap(inout int unsigned calm_left);
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			calm_left = $urandom_range(10, 60);
			return 0;
		end
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			err_count++;
		end
	endfunction

	// Offer one byte, wait for the handshake, queue its prediction
	task automatic push_byte(input logic [7:0] b);
		int unsigned gap;
		gap = draw_gap(send_calm);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(deframe_byte(b));
		bytes_sent++;
	endtask

	task automatic send_header(input logic [31:0] head, input logic [31:0] size);
		for (int i = 3; i >= 0; i--)
			push_byte(head[i*8 +: 8]);
		for (int i = 3; i >= 0; i--)
			push_byte(size[i*8 +: 8]);
	endtask

	// Stop offering and wait until every result item has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_max_len(input logic [23:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		max_len = v;
	endtask

	// One well-formed packet with random head, size and content
	task automatic send_random_packet();
		logic [31:0] head;
		logic [31:0] size;
		int unsigned pick;
		int unsigned cap;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			head = IMAGE_HEAD;
		else if (pick == 4)
			head = GREETING_HEAD;
		else if (pick == 5)
			head = IMAGE_HEAD ^ (32'd1 << $urandom_range(0, 31));
		else
			head = $urandom;
		// image packets need room for at least nine bytes
		if (head == IMAGE_HEAD && max_len < 9)
			head = ~IMAGE_HEAD;
		cap = ($urandom_range(0, 15) == 0) ? 400 : 32;
		if (cap > max_len)
			cap = 32'(max_len);
		if ($urandom_range(0, 19) == 0)
			size = cap;
		else if (head == IMAGE_HEAD)
			size = $urandom_range(9, cap);
		else if ($urandom_range(0, 5) == 0)
			size = 0;
		else
			size = $urandom_range(0, cap);
		send_header(head, size);
		repeat (size) push_byte(8'($urandom_range(0, 255)));
	endtask

	// Stimulus
	initial begin : stimulus
		int unsigned phase_end;
		logic [23:0] setting;
		logic [31:0] close_head;
		logic [31:0] close_size;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the opening table
		foreach (opening_rows[i]) begin
			push_byte(opening_rows[i].rx);
			if (opening_rows[i].typed)
				pending_results[pending_results.size() - 1] = opening_rows[i].want;
		end

		// random packets under a series of size limits
		for (int k = 0; k < 6; k++) begin
			drain_results();
			case (k)
				0, 5:    setting = 24'hFFFFFF;
				1:       setting = 24'd9;
				2:       setting = 24'd0;
				3:       setting = 24'd300;
				default: setting = 24'($urandom_range(10, 5000));
			endcase
			set_max_len(setting);
			phase_end = bytes_sent + RANDOM_ITEMS / 6;
			while (bytes_sent < phase_end)
				send_random_packet();
		end

		// close the stream with one of the two header errors
		drain_results();
		setting = ($urandom_range(0, 1) == 0) ? 24'hFFFFFF : 24'($urandom_range(8, 1000));
		set_max_len(setting);
		if ($urandom_range(0, 1) == 0) begin
			close_head = ($urandom_range(0, 1) == 0) ? IMAGE_HEAD : $urandom;
			close_size = ($urandom_range(0, 1) == 0) ? 32'hFFFFFFFF : {8'd0, setting} + 1;
		end else begin
			close_head = IMAGE_HEAD;
			close_size = $urandom_range(0, 8);
		end
		send_header(close_head, close_size);

		// closed stream ignores further bytes
		repeat (16) push_byte(8'($urandom_range(0, 255)));

		drain_results();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result sink: stall at random, hold off twice for a long stretch, check each item
	initial begin : result_sink
		int unsigned stall;
		result_t     got;
		result_t     want;
		forever begin
			if (results_seen == 300 || results_seen == 900)
				stall = LONG_HOLD;
			else
				stall = draw_gap(recv_calm);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got = '{m_tdata[7:0], m_tuser[0], m_tuser[1], m_tlast,
				m_tdata[9:8], m_tdata[11:10], m_tdata[12]};
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result item, expected none, got 0x%0h",
					$time, got);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("payload_byte", want.payload_byte, got.payload_byte);
				compare_field("payload_valid", want.payload_valid, got.payload_valid);
				compare_field("payload_is_image", want.payload_is_image,
					got.payload_is_image);
				compare_field("payload_last", want.payload_last, got.payload_last);
				compare_field("reply_code", want.reply_code, got.reply_code);
				compare_field("error_code", want.error_code, got.error_code);
				compare_field("closed", want.closed, got.closed);
				compare_field("tdata padding", 0, m_tdata[15:13]);
			end
		end
	end

endmodule
